[hw/rtl/sed_pkg.sv]
// Package for the string escape decoder: status codes, character codes
// and the result record passed from the decode core to the top level.
// No dependencies.
package sed_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned StatusW = 2;

    typedef enum logic [StatusW-1:0] {
        ST_CHAR   = 2'd0,
        ST_END    = 2'd1,
        ST_BADESC = 2'd2,
        ST_BADDIG = 2'd3
    } t_status;

    localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
    localparam logic [ByteW-1:0] ChDquote    = 8'h22;
    localparam logic [ByteW-1:0] ChSquote    = 8'h27;
    localparam logic [ByteW-1:0] ChDot       = 8'h2E;
    localparam logic [ByteW-1:0] ChLowT      = 8'h74;
    localparam logic [ByteW-1:0] ChLowR      = 8'h72;
    localparam logic [ByteW-1:0] ChLowN      = 8'h6E;
    localparam logic [ByteW-1:0] ChLowX      = 8'h78;
    localparam logic [ByteW-1:0] ChZero      = 8'h30;
    localparam logic [ByteW-1:0] ChNine      = 8'h39;
    localparam logic [ByteW-1:0] ChUpA       = 8'h41;
    localparam logic [ByteW-1:0] ChUpZ       = 8'h5A;
    localparam logic [ByteW-1:0] ChTab       = 8'h09;
    localparam logic [ByteW-1:0] ChCr        = 8'h0D;
    localparam logic [ByteW-1:0] ChLf        = 8'h0A;
    localparam logic [ByteW-1:0] DigitBias   = 8'd10;

    typedef struct packed {
        logic             emit;
        logic [ByteW-1:0] out_byte;
        t_status          status;
    } t_sed_result;

endpackage

[hw/rtl/sed_core.sv]
// Decode core of the string escape decoder: holds the phase and the first
// hex digit, and decodes one byte per enabled cycle.
// Depends on sed_pkg.
module sed_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [sed_pkg::ByteW-1:0]  i_byte,
    input  logic                       i_last,
    output sed_pkg::t_sed_result       o_result
);
    import sed_pkg::*;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_hex_high, n_hex_high;
    logic        is_digit;
    logic [5:0]  digit_val;
    logic [ByteW-1:0] diff;

    // Base-36 digit value: '0'-'9' give 0-9, 'A'-'Z' give 10-35.
    always_comb begin
        diff      = '0;
        is_digit  = 1'b0;
        digit_val = '0;
        if (i_byte >= ChZero && i_byte <= ChNine) begin
            diff      = i_byte - ChZero;
            is_digit  = 1'b1;
            digit_val = diff[5:0];
        end else if (i_byte >= ChUpA && i_byte <= ChUpZ) begin
            diff      = i_byte - ChUpA + DigitBias;
            is_digit  = 1'b1;
            digit_val = diff[5:0];
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hex_high = r_hex_high;
        o_result   = '{emit: 1'b0, out_byte: '0, status: ST_CHAR};
        unique case (r_phase)
            PH_OPEN: begin
                if (i_last) begin
                    o_result.emit   = 1'b1;
                    o_result.status = ST_END;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (i_last) begin
                    n_phase         = PH_OPEN;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_END;
                end else if (i_byte == ChBackslash) begin
                    n_phase = PH_ESC;
                end else begin
                    o_result.emit     = 1'b1;
                    o_result.out_byte = i_byte;
                end
            end
            PH_ESC: begin
                if (i_last) begin
                    n_phase         = PH_OPEN;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_BADESC;
                end else begin
                    n_phase       = PH_BODY;
                    o_result.emit = 1'b1;
                    unique case (i_byte)
                        ChLowT:      o_result.out_byte = ChTab;
                        ChLowR:      o_result.out_byte = ChCr;
                        ChLowN:      o_result.out_byte = ChLf;
                        ChBackslash: o_result.out_byte = ChBackslash;
                        ChDquote:    o_result.out_byte = ChDquote;
                        ChSquote:    o_result.out_byte = ChSquote;
                        ChDot:       o_result.emit = 1'b0;
                        ChLowX: begin
                            o_result.emit = 1'b0;
                            n_phase       = PH_HEX1;
                        end
                        default: begin
                            n_phase         = PH_ERR;
                            o_result.status = ST_BADESC;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (i_last) begin
                    n_phase         = PH_OPEN;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_BADESC;
                end else if (!is_digit) begin
                    n_phase         = PH_ERR;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_BADDIG;
                end else if (r_phase == PH_HEX1) begin
                    n_hex_high = digit_val[3:0];
                    n_phase    = PH_HEX2;
                end else begin
                    // The second digit is ORed in whole, so values above 15 spill up.
                    n_phase           = PH_BODY;
                    o_result.emit     = 1'b1;
                    o_result.out_byte = {r_hex_high, 4'h0} | {2'b00, digit_val};
                end
            end
            default: begin
                if (i_last) begin
                    n_phase         = PH_OPEN;
                    o_result.emit   = 1'b1;
                    o_result.status = ST_END;
                end else begin
                    n_phase = PH_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPEN;
            r_hex_high <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_hex_high <= n_hex_high;
        end
    end

endmodule

[hw/rtl/string_escape_decoder.sv]
// Top level of the string escape decoder: input register, decode core and
// result register on stream handshakes.
// Depends on sed_pkg and sed_core.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] data_byte, tlast is_last
//   m_axis    out        tdata[7:0] out_byte, tuser[1:0] status
//
// One byte is accepted per cycle unless m_axis stalls. Its result, if any, is
// put on m_axis when the result register loads the decode of the input
// register. Bytes that decode to nothing (the opening quote, a
// backslash, the letter of a \x or \. escape, the first \x digit and bytes
// dropped after an error) leave no result.
// Synchronous active-low reset returns the decoder to waiting for an opening
// quote. A stall on m_axis holds the result register and backs up into the
// input register, which then drops s_axis_tready.
module string_escape_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import sed_pkg::*;

    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;
    logic             r_in_last;
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_byte;
    t_status          r_out_status;
    logic             advance;
    t_sed_result      result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    sed_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && result.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && result.emit) begin
            r_out_byte   <= result.out_byte;
            r_out_status <= result.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_status;

endmodule
